// File: sv/vsd_pkg.sv
`default_nettype none

package vsd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 22;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned PHASE_W  = 7;
  localparam int unsigned LINE_W   = 10;
  localparam int unsigned LEN_W    = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_LINE_SAMPLES = 65535;
  localparam int unsigned MAX_FRAME_LINES  = 1023;

  localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(MAX_LINE_SAMPLES);
  localparam logic [LINE_W-1:0] LINES_CAP = LINE_W'(MAX_FRAME_LINES);

  localparam int unsigned AGC_PERIOD = 100;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(AGC_PERIOD - 1);

  // sum / AGC_PERIOD as a multiply by a rounded-up reciprocal; exact for any SUM_W-bit sum
  localparam int unsigned RECIP_SHIFT = SUM_W + $clog2(AGC_PERIOD);
  localparam int unsigned RECIP_W     = RECIP_SHIFT - $clog2(AGC_PERIOD) + 1;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + AGC_PERIOD - 1) / AGC_PERIOD;

  localparam logic [LEN_W-1:0]   LINE_LENGTH_RST = 16'd1024;
  localparam logic [LINE_W-1:0]  FRAME_LINES_RST = 10'd625;
  localparam logic [LEVEL_W-1:0] LEVEL_RST       = 16'd16383;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH = 2'd0,
    CFG_FRAME_LINES = 2'd1,
    CFG_INTERLACED  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               update;
    logic [LEVEL_W-1:0] level;
  } agc_upd_t;

endpackage

`default_nettype wire

// File: sv/vsd_if.sv
`default_nettype none

interface vsd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vsd_pkg::SAMPLE_W-1:0] video_sample;

  modport source (output valid, output video_sample, input ready);
  modport sink   (input valid, input video_sample, output ready);
endinterface

interface vsd_out_if;
  logic valid;
  logic ready;
  logic hsync;
  logic field_now;
  logic locked;

  modport source (output valid, output hsync, output field_now, output locked,
                  input ready);
  modport sink   (input valid, input hsync, input field_now, input locked,
                  output ready);
endinterface

`default_nettype wire

// File: sv/vsd_agc.sv
`default_nettype none

module vsd_agc (
  input  logic [vsd_pkg::SUM_W-1:0]    level_sum,
  input  logic [vsd_pkg::SAMPLE_W:0]   mag,
  input  logic                         phase_zero,
  output logic [vsd_pkg::SUM_W-1:0]    sum_nxt,
  output vsd_pkg::agc_upd_t            upd
);
  import vsd_pkg::*;

  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  logic [SUM_W:0]    sum_full;
  logic [SUM_W-1:0]  sum_sat;
  logic [PROD_W-1:0] prod;

  always_comb begin
    sum_full = {1'b0, level_sum} + (SUM_W+1)'(mag);
    sum_sat  = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];
    prod     = PROD_W'(sum_sat) * PROD_W'(RECIP_MUL);
    upd.update = phase_zero && (sum_sat != '0);
    upd.level  = LEVEL_W'(prod >> RECIP_SHIFT);
    sum_nxt    = upd.update ? '0 : sum_sat;
  end

endmodule

`default_nettype wire

// File: sv/video_sync_detector_with_agc_unit.sv
`default_nettype none

// channel   dir  payload                              transfer
// in_bus    in   video_sample (s16)                   valid & ready
// out_bus   out  hsync, field_now, locked             valid & ready
// cfg_*     in   cfg_index (2), cfg_data (16)         cfg_we
//
// One sample per cycle; each result comes from the output register, in the cycle
// after its sample. The AGC divide is a reciprocal multiply in the same cycle.
// in_bus.ready drops only while a result is held and out_bus.ready is low.
// Synchronous reset restores the register defaults; no clearing pass.
module video_sync_detector_with_agc_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  vsd_in_if.sink                           in_bus,
  vsd_out_if.source                        out_bus
);
  import vsd_pkg::*;

  logic [LEN_W-1:0]   line_length_r;
  logic [LINE_W-1:0]  frame_lines_r;
  logic               interlaced_r;

  logic [SUM_W-1:0]   level_sum_r, level_sum_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               thr_init_r, thr_init_nxt;
  logic [COUNT_W-1:0] since_r, since_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic               field_r, field_nxt;
  logic               sync_r, sync_nxt;

  logic out_valid_r, out_start_r, out_field_r, out_locked_r;

  logic                        accept;
  logic signed [SAMPLE_W:0]    neg_x;
  logic [SAMPLE_W:0]           mag;
  logic [LEN_W-1:0]            len;
  logic [LINE_W-1:0]           lines;
  agc_upd_t                    upd;
  logic [LEVEL_W-1:0]          level_use;
  logic                        thr_init_use;
  logic signed [SAMPLE_W+3:0]  five_x;
  logic signed [SAMPLE_W+3:0]  three_q;
  logic                        below;
  logic                        start;
  logic [LINE_W:0]             line_inc;
  logic [COUNT_W-1:0]          since_inc;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  assign neg_x = -{in_bus.video_sample[SAMPLE_W-1], in_bus.video_sample};
  assign mag   = in_bus.video_sample[SAMPLE_W-1] ? $unsigned(neg_x)
                                                 : {1'b0, in_bus.video_sample};

  vsd_agc u_agc (
    .level_sum  (level_sum_r),
    .mag        (mag),
    .phase_zero (phase_r == '0),
    .sum_nxt    (level_sum_nxt),
    .upd        (upd)
  );

  always_comb begin
    len   = (line_length_r > LEN_CAP) ? LEN_CAP : line_length_r;
    lines = (frame_lines_r > LINES_CAP) ? LINES_CAP : frame_lines_r;

    level_use    = upd.update ? upd.level : level_r;
    thr_init_use = thr_init_r && !upd.update;

    // sample < -floor(3q/5)  <=>  5*(-sample) > 3q
    five_x  = ((SAMPLE_W+4)'(neg_x) <<< 2) + (SAMPLE_W+4)'(neg_x);
    three_q = $signed((SAMPLE_W+4)'({level_use, 1'b0}) + (SAMPLE_W+4)'(level_use));
    // power-up threshold is -32767: only full-scale negative lies below it
    below = thr_init_use ? (in_bus.video_sample[SAMPLE_W-1] &&
                            (in_bus.video_sample[SAMPLE_W-2:0] == '0))
                         : (five_x > three_q);
    start = below && (since_r > COUNT_W'(len >> 1));

    line_inc  = {1'b0, line_r} + (LINE_W+1)'(1);
    since_inc = (since_r == '1) ? since_r : since_r + COUNT_W'(1);

    level_nxt    = level_use;
    thr_init_nxt = thr_init_use;
    line_nxt     = line_r;
    field_nxt    = field_r;
    sync_nxt     = sync_r;
    if (start) begin
      sync_nxt  = 1'b1;
      since_nxt = '0;
      phase_nxt = '0;
      if (line_inc >= (LINE_W+1)'(lines)) begin
        line_nxt = '0;
        if (interlaced_r) begin
          field_nxt = !field_r;
        end
      end else begin
        line_nxt = line_inc[LINE_W-1:0];
      end
    end else begin
      since_nxt = since_inc;
      phase_nxt = (phase_r == PHASE_LAST) ? '0 : phase_r + PHASE_W'(1);
      if (since_inc > {len, 1'b0}) begin
        sync_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= LINE_LENGTH_RST;
      frame_lines_r <= FRAME_LINES_RST;
      interlaced_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_LENGTH: line_length_r <= cfg_data;
        CFG_FRAME_LINES: frame_lines_r <= cfg_data[LINE_W-1:0];
        CFG_INTERLACED:  interlaced_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_sum_r <= '0;
      level_r     <= LEVEL_RST;
      thr_init_r  <= 1'b1;
      since_r     <= '0;
      phase_r     <= '0;
      line_r      <= '0;
      field_r     <= 1'b0;
      sync_r      <= 1'b0;
    end else if (accept) begin
      level_sum_r <= level_sum_nxt;
      level_r     <= level_nxt;
      thr_init_r  <= thr_init_nxt;
      since_r     <= since_nxt;
      phase_r     <= phase_nxt;
      line_r      <= line_nxt;
      field_r     <= field_nxt;
      sync_r      <= sync_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_start_r  <= start;
      out_field_r  <= field_r;
      out_locked_r <= sync_nxt;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.hsync     = out_start_r;
  assign out_bus.field_now = out_field_r;
  assign out_bus.locked    = out_locked_r;

endmodule

`default_nettype wire

// File: verif/vsd_checker.sv
`timescale 1ns / 1ps

module vsd_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [vsd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_hsync,
  input  logic                                out_field_now,
  input  logic                                out_locked,
  output int unsigned                         mismatches,
  output int unsigned                         pending,
  output int unsigned                         results_checked,
  output int unsigned                         hsync_seen
);
  import vsd_pkg::*;

  typedef struct packed {
    logic hsync;
    logic field_now;
    logic locked;
  } sync_flags_t;

  localparam int unsigned SUM_SAT = (1 << SUM_W) - 1;
  localparam logic [COUNT_W-1:0] SINCE_SAT = '1;
  localparam int THR_NUM = 6;
  localparam int THR_DEN = 10;

  // register copies
  logic [LEN_W-1:0]  len_reg;
  logic [LINE_W-1:0] lines_reg;
  logic              interlace_reg;

  // detector state
  logic [SUM_W-1:0]          mag_sum;
  logic [LEVEL_W-1:0]        avg_level;
  logic signed [SAMPLE_W-1:0] slice_thr;
  logic [COUNT_W-1:0]        since_sync;
  logic [PHASE_W-1:0]        agc_phase;
  logic [LINE_W-1:0]         line_cnt;
  logic                      field_flag;
  logic                      lock_flag;

  sync_flags_t expected_q[$];
  int unsigned err_cnt = 0;
  int unsigned n_checked = 0;
  int unsigned n_starts = 0;

  task automatic reset_detector();
    len_reg       = LINE_LENGTH_RST;
    lines_reg     = FRAME_LINES_RST;
    interlace_reg = 1'b1;
    mag_sum       = '0;
    avg_level     = LEVEL_RST;
    slice_thr     = -16'sd32767;
    since_sync    = '0;
    agc_phase     = '0;
    line_cnt      = '0;
    field_flag    = 1'b0;
    lock_flag     = 1'b0;
  endtask

  task automatic predict_sample(input logic signed [SAMPLE_W-1:0] s, output sync_flags_t r);
    int mag, acc, nxt;
    mag = (s < 0) ? -int'(s) : int'(s);
    acc = int'(mag_sum) + mag;
    if (acc > SUM_SAT) acc = SUM_SAT;
    // AGC refresh on phase zero, only when something accumulated
    if (agc_phase == '0 && acc != 0) begin
      avg_level = LEVEL_W'(acc / AGC_PERIOD);
      acc = 0;
      slice_thr = SAMPLE_W'(-((int'(avg_level) * THR_NUM) / THR_DEN));
    end
    mag_sum = SUM_W'(acc);

    r.field_now = field_flag;
    r.hsync     = 1'b0;
    if (s < slice_thr && int'(since_sync) > int'(len_reg) / 2) begin
      r.hsync = 1'b1;
      lock_flag = 1'b1;
      nxt = int'(line_cnt) + 1;
      if (nxt >= int'(lines_reg)) begin
        nxt = 0;
        if (interlace_reg) field_flag = ~field_flag;
      end
      line_cnt   = LINE_W'(nxt);
      since_sync = '0;
      agc_phase  = '0;
    end else begin
      if (since_sync != SINCE_SAT) since_sync = since_sync + 1'b1;
      agc_phase = (agc_phase == PHASE_LAST) ? '0 : agc_phase + 1'b1;
      if (int'(since_sync) > 2 * int'(len_reg)) lock_flag = 1'b0;
    end
    r.locked = lock_flag;
  endtask

  always @(posedge clk) begin : monitor
    sync_flags_t exp_r;
    sync_flags_t got_r;
    if (!rst_n) begin
      reset_detector();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LINE_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          CFG_FRAME_LINES: lines_reg = cfg_data[LINE_W-1:0];
          CFG_INTERLACED:  interlace_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_sample(in_sample, exp_r);
        expected_q.push_back(exp_r);
      end
      if (out_valid && out_ready) begin
        got_r = {out_hsync, out_field_now, out_locked};
        n_checked++;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] unexpected result: hsync=%0b field=%0b locked=%0b",
                     $realtime, got_r.hsync, got_r.field_now, got_r.locked);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.hsync) n_starts++;
          if (got_r !== exp_r) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] result %0d mismatch: exp sync/field/lock=%0b/%0b/%0b got %0b/%0b/%0b",
                       $realtime, n_checked, exp_r.hsync, exp_r.field_now, exp_r.locked,
                       got_r.hsync, got_r.field_now, got_r.locked);
          end
        end
      end
    end
    pending         <= expected_q.size();
    mismatches      <= err_cnt;
    results_checked <= n_checked;
    hsync_seen      <= n_starts;
  end

endmodule

// File: verif/video_sync_detector_with_agc_unit_tb.sv
`timescale 1ns / 1ps

module video_sync_detector_with_agc_unit_tb;
  import vsd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned QUIET_RUN    = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(3);
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] CORNER [14] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA,
    16'sh8001, 16'sh7FFE, 16'sh0064, 16'shFF9C, 16'sh4000, 16'shC000, 16'sh0000};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        rx_idle_en = 1'b1;
  logic        tx_idle_en = 1'b1;
  int unsigned hold_req_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned settings_cnt = 0;
  int unsigned cycle_cnt = 0;

  int unsigned mismatches, pending, results_checked, hsync_seen;

  vsd_in_if  in_bus ();
  vsd_out_if out_bus ();

  video_sync_detector_with_agc_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  vsd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_bus.valid),
    .in_ready        (in_bus.ready),
    .in_sample       (in_bus.video_sample),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_hsync       (out_bus.hsync),
    .out_field_now   (out_bus.field_now),
    .out_locked      (out_bus.locked),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .hsync_seen      (hsync_seen)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random back-pressure per transaction, plus requested long hold-offs
  initial begin : rx_side
    int unsigned rx_wait, w, hold_served;
    rx_wait = 0;
    hold_served = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      w = rx_wait;
      if (out_bus.valid && out_bus.ready) w = rx_idle_en ? $urandom_range(0, 6) : 0;
      if (hold_req_cnt != hold_served) begin
        hold_served = hold_req_cnt;
        w = LONG_HOLD;
      end
      if (w > 0) begin
        rx_wait = w - 1;
        out_bus.ready <= 1'b0;
      end else begin
        rx_wait = 0;
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.video_sample <= s;
    do @(posedge clk); while (!in_bus.ready);
    sent_cnt++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input logic [LEN_W-1:0] len, input logic [LINE_W-1:0] lines,
                          input logic il);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LINE_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= CFG_FRAME_LINES;
    cfg_data  <= {junk[CFG_DATA_W-1:LINE_W], lines};
    @(posedge clk);
    cfg_index <= CFG_INTERLACED;
    cfg_data  <= {junk[CFG_DATA_W-1:1], il};
    @(posedge clk);
    // unmapped index must be ignored
    cfg_index <= CFG_IDX_SPARE;
    cfg_data  <= ~junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] sync_tip();
    return SAMPLE_W'(int'(FULL_NEG) + int'($urandom_range(0, 6000)));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] video_level();
    if ($urandom_range(0, 19) == 0) return SAMPLE_W'(-int'($urandom_range(1, 300)));
    return SAMPLE_W'($urandom_range(500, 24000));
  endfunction

  task automatic send_video(input int unsigned n, input int unsigned nom_len);
    int unsigned stop_at, kind, llen, sw;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        llen = nom_len + $urandom_range(0, 2);
        if (llen == 0) llen = 1;
        sw = $urandom_range(1, 3);
        if (sw > llen) sw = llen;
        repeat (sw) send_sample(sync_tip());
        repeat (llen - sw) send_sample(video_level());
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 6)) send_sample(SAMPLE_W'($urandom));
      end else if (kind < 95) begin
        // truncated line, or a line whose sync tip went missing
        if (kind < 90) send_sample(sync_tip());
        repeat (nom_len / 3 + 1) send_sample(video_level());
      end else begin
        // silence long enough to lose lock
        repeat ((nom_len < 98) ? 2 * nom_len + 3 : 199) send_sample('0);
      end
    end
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input logic [LINE_W-1:0] lines,
                           input logic il, input logic tx_idle, input logic rx_idle,
                           input logic hold, input int unsigned n);
    set_regs(len, lines, il);
    tx_idle_en = tx_idle;
    rx_idle_en <= rx_idle;
    if (hold) hold_req_cnt <= hold_req_cnt + 1;
    send_video(n, int'(len));
    drain();
  endtask

  initial begin
    in_bus.valid        <= 1'b0;
    in_bus.video_sample <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner samples at reset register values
    foreach (CORNER[i]) send_sample(CORNER[i]);
    // full-scale negative run: AGC level reaches 32768
    repeat (220) send_sample(FULL_NEG);
    drain();

    run_phase(16'd2, 10'd1, 1'b1, 1'b1, 1'b1, 1'b0, 200);
    run_phase(16'd0, 10'd0, 1'b1, 1'b1, 1'b1, 1'b0, 120);
    run_phase(16'd1, 10'd3, 1'b0, 1'b0, 1'b1, 1'b0, 120);
    run_phase(16'd16, 10'd5, 1'b1, 1'b0, 1'b0, 1'b1, 200);
    run_phase(16'd40, 10'd1023, 1'b0, 1'b1, 1'b1, 1'b0, 220);
    // frame length drops below the current line count
    run_phase(16'd24, 10'd2, 1'b1, 1'b1, 1'b0, 1'b0, 180);

    // silence at maximum line length: too early for a sync or for lock loss
    set_regs(16'hFFFF, 10'd625, 1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (QUIET_RUN) send_sample('0);
    send_sample(FULL_NEG);
    repeat (5) send_sample(FULL_POS);
    drain();

    run_phase(16'd12, 10'd4, 1'b1, 1'b0, 1'b1, 1'b0, 160);

    $display("Sent %0d samples over %0d register settings; %0d results checked, %0d line starts.",
             sent_cnt, settings_cnt, results_checked, hsync_seen);
    $display("Run included full-scale AGC input, lock loss on silence and a %0d-cycle output stall.",
             LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/vsd_pkg.sv
sv/vsd_if.sv
sv/vsd_agc.sv
sv/video_sync_detector_with_agc_unit.sv
verif/vsd_checker.sv
verif/video_sync_detector_with_agc_unit_tb.sv
